FILE: src/sdc_pkg.sv
`timescale 1ns / 1ps

package sdc_pkg;

  // Fixed-point position of the mixed sums
  localparam int FRACTION_SHIFT = 8;

  localparam int MIX_W    = 32;
  localparam int ACC_W    = MIX_W + 1;
  localparam int LEVEL_W  = 17;
  localparam int SAMPLE_W = 16;

  localparam logic signed [ACC_W-1:0] MIX_OFFSET =
      ACC_W'(64'sh10000 <<< FRACTION_SHIFT);
  localparam logic signed [ACC_W-1:0] MIX_TOP =
      ACC_W'((64'sh20000 <<< FRACTION_SHIFT) - 1);

  // DC tracker scaling
  localparam int DC_SCALE_SHIFT = 14;
  localparam int DC_OUT_SHIFT   = 15;
  localparam int RATE_SHIFT     = 6;
  localparam logic signed [31:0] DC_BIAS  = 32'sh4000_0000;
  localparam logic signed [31:0] DC_ROUND = 32'sh0000_7FFF;

  localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 16'hFFFF;

  // Configuration registers
  localparam int ADDR_W  = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_FILTER_MODE   = 2'd0;
  localparam logic [1:0] REG_RATE_FACTOR   = 2'd1;
  localparam logic [1:0] REG_SMOOTH_WEIGHT = 2'd2;

  localparam int MODE_W   = 3;
  localparam int RATE_W   = 7;
  localparam int WEIGHT_W = 6;
  localparam logic [MODE_W-1:0]   MODE_LOWPASS  = 3'd0;
  localparam logic [MODE_W-1:0]   MODE_AVERAGE  = 3'd1;
  localparam int                  MODE_BYPASS_BIT = 2;
  localparam logic [RATE_W-1:0]   RATE_RESET    = 7'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 6'd25;

  // Shared divider: radix-2 restoring, several quotient bits per cycle
  localparam int DIV_W      = 32;
  localparam int DVSR_W     = RATE_W + RATE_SHIFT;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_left;
    logic signed [MIX_W-1:0] mix_right;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } samples_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP,
    S_DC_START,
    S_DC_WAIT,
    S_DC_UPDATE,
    S_DC_OUT,
    S_SMOOTH,
    S_LP_START,
    S_LP_WAIT,
    S_STORE,
    S_OUTPUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic clamp;
    logic dc_start;
    logic dc_update;
    logic dc_out;
    logic smooth;
    logic lp_start;
    logic lp_take;
    logic store;
    logic out_load;
    logic ch;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/sdc_div.sv
`timescale 1ns / 1ps

module sdc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sdc_pkg::DIV_W-1:0]    dividend,
  input  logic [sdc_pkg::DVSR_W-1:0]   divisor,
  output logic [sdc_pkg::DIV_W-1:0]    quotient,
  output logic                         done
);

  logic [sdc_pkg::DVSR_W-1:0]    rem;
  logic [sdc_pkg::DIV_W-1:0]     quo;
  logic [sdc_pkg::DVSR_W-1:0]    dvsr;
  logic [sdc_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;

  logic [sdc_pkg::DVSR_W-1:0]    rem_next;
  logic [sdc_pkg::DIV_W-1:0]     quo_next;
  logic [sdc_pkg::DVSR_W:0]      trial;

  // Shift in one dividend bit and try a subtract, several times a cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < sdc_pkg::DIV_STEPS; i++) begin
      trial    = {rem_next, quo_next[sdc_pkg::DIV_W-1]};
      quo_next = {quo_next[sdc_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr}) begin
        rem_next    = sdc_pkg::DVSR_W'(trial - {1'b0, dvsr});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[sdc_pkg::DVSR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sdc_pkg::DIV_CNT_W'(sdc_pkg::DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

FILE: src/sdc_dp.sv
`timescale 1ns / 1ps

module sdc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  sdc_pkg::dp_cmd_t                 cmd,
  output sdc_pkg::dp_status_t              status,
  input  logic                             filter_clear,
  input  logic [sdc_pkg::MODE_W-1:0]       filter_mode,
  input  logic [sdc_pkg::RATE_W-1:0]       rate_factor,
  input  logic [sdc_pkg::WEIGHT_W-1:0]     smooth_weight,
  input  sdc_pkg::frame_t                  frame,
  output sdc_pkg::samples_t                samples,
  output logic                             sample_valid,
  input  logic                             sample_stall
);

  sdc_pkg::frame_t                    frame_hold;
  logic [sdc_pkg::LEVEL_W-1:0]        level;
  logic [sdc_pkg::SAMPLE_W-1:0]       work;
  logic signed [31:0]                 track [2];
  logic                               primed [2];
  logic [sdc_pkg::SAMPLE_W-1:0]       prev [2];
  logic                               q_neg;
  logic [21:0]                        prod_new;
  logic [22:0]                        prod_prev;
  logic [sdc_pkg::SAMPLE_W-1:0]       res_left;
  logic [sdc_pkg::SAMPLE_W-1:0]       res_right;

  logic [sdc_pkg::RATE_W-1:0]         rate_eff;
  logic signed [sdc_pkg::MIX_W-1:0]   mix_sel;
  logic signed [sdc_pkg::ACC_W-1:0]   acc;
  logic signed [sdc_pkg::ACC_W-1:0]   acc_clamped;
  logic [sdc_pkg::LEVEL_W-1:0]        level_in;
  logic signed [31:0]                 target_in;
  logic signed [31:0]                 target;
  logic signed [32:0]                 diff;
  logic [32:0]                        diff_mag;
  logic [sdc_pkg::DIV_W-1:0]          div_dividend;
  logic [sdc_pkg::DVSR_W-1:0]         div_divisor;
  logic [sdc_pkg::DIV_W-1:0]          quotient;
  logic signed [31:0]                 q_signed;
  logic signed [31:0]                 track_sum;
  logic signed [16:0]                 track_scaled;
  logic signed [18:0]                 level_dc;
  logic [17:0]                        avg_sum;
  logic [23:0]                        lp_num;
  logic [7:0]                         lp_den;
  logic                               div_start;
  logic                               div_done;
  logic                               out_free;

  assign rate_eff = (rate_factor == '0) ? sdc_pkg::RATE_W'(1) : rate_factor;

  // Offset, clamp and drop the fraction
  assign mix_sel = cmd.ch ? frame_hold.mix_right : frame_hold.mix_left;
  assign acc     = {mix_sel[sdc_pkg::MIX_W-1], mix_sel} + sdc_pkg::MIX_OFFSET;
  always_comb begin
    if (acc < 0) begin
      acc_clamped = '0;
    end else if (acc > sdc_pkg::MIX_TOP) begin
      acc_clamped = sdc_pkg::MIX_TOP;
    end else begin
      acc_clamped = acc;
    end
  end
  assign level_in = acc_clamped[sdc_pkg::FRACTION_SHIFT +: sdc_pkg::LEVEL_W];

  assign target_in = $signed({1'b0, level_in, sdc_pkg::DC_SCALE_SHIFT'(0)}) - sdc_pkg::DC_BIAS;
  assign target    = $signed({1'b0, level, sdc_pkg::DC_SCALE_SHIFT'(0)}) - sdc_pkg::DC_BIAS;

  // Tracker step: magnitude into the divider, sign kept aside
  assign diff     = {track[cmd.ch][31], track[cmd.ch]} - {target[31], target};
  assign diff_mag = diff[32] ? (33'd0 - 33'(diff)) : 33'(diff);
  assign q_signed = q_neg ? (32'sd0 - $signed(quotient)) : $signed(quotient);

  // Tracker divided by 2^15, truncated toward zero
  assign track_sum    = track[cmd.ch] + (track[cmd.ch][31] ? sdc_pkg::DC_ROUND : 32'sd0);
  assign track_scaled = track_sum[31:sdc_pkg::DC_OUT_SHIFT];
  assign level_dc     = $signed({3'b000, level[sdc_pkg::LEVEL_W-1:1]})
                      - $signed({{2{track_scaled[16]}}, track_scaled});

  assign avg_sum = {2'b00, work} + {1'b0, work, 1'b0} + {2'b00, prev[cmd.ch]};
  assign lp_num  = {2'b00, prod_new} + {1'b0, prod_prev};
  assign lp_den  = {2'b00, smooth_weight} + {1'b0, rate_eff};

  assign div_start    = cmd.dc_start | cmd.lp_start;
  assign div_dividend = cmd.dc_start ? diff_mag[sdc_pkg::DIV_W-1:0]
                                     : {8'd0, lp_num};
  assign div_divisor  = cmd.dc_start ? {rate_eff, sdc_pkg::RATE_SHIFT'(0)}
                                     : {5'd0, lp_den};

  sdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // Per-channel filter state
  always_ff @(posedge clk) begin
    if (rst || filter_clear) begin
      for (int c = 0; c < 2; c++) begin
        track[c]  <= '0;
        primed[c] <= 1'b0;
        prev[c]   <= sdc_pkg::SAMPLE_BIAS;
      end
    end else begin
      if (cmd.clamp && !filter_mode[sdc_pkg::MODE_BYPASS_BIT] && !primed[cmd.ch]) begin
        track[cmd.ch]  <= target_in;
        primed[cmd.ch] <= 1'b1;
      end
      if (cmd.dc_update) begin
        track[cmd.ch] <= track[cmd.ch] - q_signed;
      end
      if (cmd.smooth && filter_mode == sdc_pkg::MODE_AVERAGE) begin
        prev[cmd.ch] <= work;
      end
      if (cmd.lp_take) begin
        prev[cmd.ch] <= quotient[sdc_pkg::SAMPLE_W-1:0];
      end
    end
  end

  // Working values
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      frame_hold <= frame;
    end
    if (cmd.clamp) begin
      level <= level_in;
      work  <= level_in[sdc_pkg::LEVEL_W-1:1];
    end
    if (cmd.dc_start) begin
      q_neg <= diff[32];
    end
    if (cmd.dc_out) begin
      if (level_dc < 0) begin
        work <= '0;
      end else if (level_dc[17:16] != 2'b00) begin
        work <= sdc_pkg::SAMPLE_MAX;
      end else begin
        work <= level_dc[sdc_pkg::SAMPLE_W-1:0];
      end
    end
    if (cmd.smooth) begin
      prod_new  <= work * smooth_weight;
      prod_prev <= prev[cmd.ch] * rate_eff;
      if (filter_mode == sdc_pkg::MODE_AVERAGE) begin
        work <= avg_sum[17:2];
      end
    end
    if (cmd.lp_take) begin
      work <= quotient[sdc_pkg::SAMPLE_W-1:0];
    end
    if (cmd.store) begin
      if (cmd.ch) begin
        res_right <= work ^ sdc_pkg::SAMPLE_BIAS;
      end else begin
        res_left <= work ^ sdc_pkg::SAMPLE_BIAS;
      end
    end
    if (cmd.out_load) begin
      samples.sample_left  <= $signed(res_left);
      samples.sample_right <= $signed(res_right);
    end
  end

  // Output register
  assign out_free = !sample_valid || !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (cmd.out_load) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = out_free;

endmodule

FILE: src/sdc_ctrl.sv
`timescale 1ns / 1ps

module sdc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         frame_valid,
  output logic                         frame_stall,
  input  logic [sdc_pkg::MODE_W-1:0]   filter_mode,
  input  sdc_pkg::dp_status_t          status,
  output sdc_pkg::dp_cmd_t             cmd
);

  sdc_pkg::state_t state;
  sdc_pkg::state_t state_next;
  logic            ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdc_pkg::S_IDLE;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sdc_pkg::S_STORE) begin
        ch <= ~ch;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sdc_pkg::S_IDLE: begin
        if (frame_valid) begin
          state_next = sdc_pkg::S_CLAMP;
        end
      end
      sdc_pkg::S_CLAMP: begin
        state_next = filter_mode[sdc_pkg::MODE_BYPASS_BIT] ? sdc_pkg::S_SMOOTH
                                                           : sdc_pkg::S_DC_START;
      end
      sdc_pkg::S_DC_START: state_next = sdc_pkg::S_DC_WAIT;
      sdc_pkg::S_DC_WAIT: begin
        if (status.div_done) begin
          state_next = sdc_pkg::S_DC_UPDATE;
        end
      end
      sdc_pkg::S_DC_UPDATE: state_next = sdc_pkg::S_DC_OUT;
      sdc_pkg::S_DC_OUT:    state_next = sdc_pkg::S_SMOOTH;
      sdc_pkg::S_SMOOTH: begin
        state_next = (filter_mode == sdc_pkg::MODE_LOWPASS) ? sdc_pkg::S_LP_START
                                                            : sdc_pkg::S_STORE;
      end
      sdc_pkg::S_LP_START: state_next = sdc_pkg::S_LP_WAIT;
      sdc_pkg::S_LP_WAIT: begin
        if (status.div_done) begin
          state_next = sdc_pkg::S_STORE;
        end
      end
      sdc_pkg::S_STORE: begin
        state_next = ch ? sdc_pkg::S_OUTPUT : sdc_pkg::S_CLAMP;
      end
      sdc_pkg::S_OUTPUT: begin
        if (status.out_free) begin
          state_next = sdc_pkg::S_IDLE;
        end
      end
      default: state_next = sdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.ch      = ch;
    frame_stall = 1'b1;
    case (state)
      sdc_pkg::S_IDLE: begin
        frame_stall = 1'b0;
        cmd.load_in = frame_valid;
      end
      sdc_pkg::S_CLAMP:     cmd.clamp     = 1'b1;
      sdc_pkg::S_DC_START:  cmd.dc_start  = 1'b1;
      sdc_pkg::S_DC_UPDATE: cmd.dc_update = 1'b1;
      sdc_pkg::S_DC_OUT:    cmd.dc_out    = 1'b1;
      sdc_pkg::S_SMOOTH:    cmd.smooth    = 1'b1;
      sdc_pkg::S_LP_START:  cmd.lp_start  = 1'b1;
      sdc_pkg::S_LP_WAIT:   cmd.lp_take   = status.div_done;
      sdc_pkg::S_STORE:     cmd.store     = 1'b1;
      sdc_pkg::S_OUTPUT:    cmd.out_load  = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/stereo_output_dc_block_smoother.sv
`timescale 1ns / 1ps

// Stereo output stage: each transfer on the frame channel carries one left and
// one right mixed sum (signed, 8 fractional bits); each transfer on the sample
// channel returns one pair of signed 16-bit samples, in order. Per channel the
// sum is offset, clamped and reduced to a 17-bit level; a leaky DC tracker,
// primed by the first level after a mode write, is removed, or with mode bit 2
// set the level is just halved; mode 0 then runs a weighted one-pole lowpass
// and mode 1 a 3:1 two-tap average. Frames are processed one at a time, left
// then right, by a controller driving a shared divider that retires 4 quotient
// bits per cycle (two divisions per channel in mode 0); mode 4 and up bypass
// the DC stage and do no smoothing. The finished pair waits in an output
// register, so the next frame is taken while the sample side stalls. Registers
// on the APB-style port: filter_mode at 0x0 (writing it clears all filter
// state), rate_factor at 0x4 (0 acts as 1), smooth_weight at 0x8; write them
// only while no frame is in flight.
module stereo_output_dc_block_smoother (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdc_pkg::ADDR_W-1:0]    paddr,
  input  logic [sdc_pkg::PDATA_W-1:0]   pwdata,
  output logic [sdc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          frame_valid,
  output logic                          frame_stall,
  input  sdc_pkg::frame_t               frame,
  output logic                          sample_valid,
  input  logic                          sample_stall,
  output sdc_pkg::samples_t             samples
);

  logic [sdc_pkg::MODE_W-1:0]   filter_mode;
  logic [sdc_pkg::RATE_W-1:0]   rate_factor;
  logic [sdc_pkg::WEIGHT_W-1:0] smooth_weight;

  logic                         cfg_write;
  logic [1:0]                   cfg_index;
  logic                         filter_clear;

  sdc_pkg::dp_cmd_t             cmd;
  sdc_pkg::dp_status_t          status;

  // Config port: no wait states, write lands on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  // A mode write restarts both channels' filters
  assign filter_clear = cfg_write && (cfg_index == sdc_pkg::REG_FILTER_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode   <= sdc_pkg::MODE_LOWPASS;
      rate_factor   <= sdc_pkg::RATE_RESET;
      smooth_weight <= sdc_pkg::WEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sdc_pkg::REG_FILTER_MODE:   filter_mode   <= pwdata[sdc_pkg::MODE_W-1:0];
        sdc_pkg::REG_RATE_FACTOR:   rate_factor   <= pwdata[sdc_pkg::RATE_W-1:0];
        sdc_pkg::REG_SMOOTH_WEIGHT: smooth_weight <= pwdata[sdc_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back; unused addresses return zero
  always_comb begin
    case (cfg_index)
      sdc_pkg::REG_FILTER_MODE:
        prdata = sdc_pkg::PDATA_W'(filter_mode);
      sdc_pkg::REG_RATE_FACTOR:
        prdata = sdc_pkg::PDATA_W'(rate_factor);
      sdc_pkg::REG_SMOOTH_WEIGHT:
        prdata = sdc_pkg::PDATA_W'(smooth_weight);
      default:
        prdata = '0;
    endcase
  end

  // Sequencer: walks left then right through clamp, DC removal and smoothing
  sdc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .filter_mode (filter_mode),
    .status      (status),
    .cmd         (cmd)
  );

  // Arithmetic, filter state, divider and output register
  sdc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .filter_clear  (filter_clear),
    .filter_mode   (filter_mode),
    .rate_factor   (rate_factor),
    .smooth_weight (smooth_weight),
    .frame         (frame),
    .samples       (samples),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall)
  );

  // One frame in flight: a transfer in closes the input until the pair is out
  assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall |=> frame_stall)
    else $error("frame taken while the previous one is still in flight");

  // A new result only appears at the end of a frame's processing
  assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(frame_stall))
    else $error("result raised without a frame in flight");

endmodule
